[rtl/spfd_pkg.sv]
// Package for the sensor pulse frame decoder.
// It holds the field widths, status codes, register map and the window compare.
// No dependencies.
package spfd_pkg;

  localparam int unsigned PulseW    = 15;
  localparam int unsigned CfgW      = 8;
  localparam int unsigned FrameW    = 40;
  localparam int unsigned CntW      = 6;
  localparam logic [CntW-1:0] FrameLen = 6'd40;
  localparam int unsigned ResW      = 16;
  localparam int unsigned AddrW     = 5;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_PREAMBLE = 3'd1,
    ST_BAD_LOW      = 3'd2,
    ST_BAD_HIGH     = 3'd3,
    ST_BAD_CHECKSUM = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_TOLERANCE  = 3'd0,
    REG_PREAMBLE   = 3'd1,
    REG_BIT_LOW    = 3'd2,
    REG_ZERO_HIGH  = 3'd3,
    REG_ONE_HIGH   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] tolerance;
    logic [CfgW-1:0] preamble_width;
    logic [CfgW-1:0] bit_low_width;
    logic [CfgW-1:0] zero_high_width;
    logic [CfgW-1:0] one_high_width;
  } cfg_t;

  typedef struct packed {
    logic              frame_start;
    logic [PulseW-1:0] low_width;
    logic [PulseW-1:0] high_width;
  } pulse_t;

  // True when expect - tol < w < expect + tol, in signed arithmetic.
  function automatic logic in_window(logic [PulseW-1:0] w, logic [CfgW-1:0] expect_w,
                                     logic [CfgW-1:0] tol);
    logic signed [PulseW+1:0] ws;
    logic signed [PulseW+1:0] lo_b;
    logic signed [PulseW+1:0] hi_b;
    ws   = signed'({2'b00, w});
    lo_b = signed'((PulseW+2)'(expect_w)) - signed'((PulseW+2)'(tol));
    hi_b = signed'((PulseW+2)'(expect_w)) + signed'((PulseW+2)'(tol));
    return (ws > lo_b) && (ws < hi_b);
  endfunction

endpackage

[rtl/sensor_pulse_frame_decoder_top.sv]
// Top level of the sensor pulse frame decoder.
// Instantiates spfd_regs, spfd_in_stage and spfd_core; depends on spfd_pkg.
//
//   channel | direction | tdata                                     | tuser
//   s_axis  | in        | [14:0] low_width, [29:15] high_width      | [0] frame_start
//   m_axis  | out       | [15:0] humidity_tenths, [31:16] temp_tenths | [2:0] status
//   apb     | in/out    | registers at byte address 4*i, 8 bits each  | -
//
// One pulse pair is accepted every cycle while the result output is not stalled; a pair that ends
// a frame or fails a check yields a result through the input register, the checks and the result register.
// Reset is asynchronous and active low and restores the default timing registers.
// A stalled result holds the pipe, while one further pair may wait in the input register.
module sensor_pulse_frame_decoder_top
  import spfd_pkg::*;
#(
  parameter int unsigned WIDTH_BITS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,  // [14:0] low_width, [29:15] high_width
  input  logic             s_axis_tuser_i,  // [0] frame_start
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [15:0] humidity_tenths, [31:16] temperature_tenths
  output logic [2:0]       m_axis_tuser_o,  // [2:0] status
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t            cfg;
  pulse_t          in_item;
  pulse_t          reg_item;
  logic            reg_valid;
  logic            core_ready;
  status_e         status;
  logic [ResW-1:0] hum;
  logic [ResW-1:0] temp;

  assign in_item.frame_start = s_axis_tuser_i;
  assign in_item.low_width   = s_axis_tdata_i[PulseW-1:0];
  assign in_item.high_width  = s_axis_tdata_i[2*PulseW-1:PulseW];

  assign m_axis_tdata_o = {temp, hum};
  assign m_axis_tuser_o = status;

  spfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spfd_in_stage #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (reg_valid),
    .out_ready_i (core_ready),
    .out_item_o  (reg_item)
  );

  spfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (reg_valid),
    .in_ready_o   (core_ready),
    .in_item_i    (reg_item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (status),
    .out_hum_o    (hum),
    .out_temp_o   (temp)
  );

endmodule

[rtl/spfd_regs.sv]
// Configuration register file of the sensor pulse frame decoder.
// Depends on spfd_pkg for the register map and the cfg_t type.
module spfd_regs
  import spfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance       <= 8'd5;
      cfg_q.preamble_width  <= 8'd80;
      cfg_q.bit_low_width   <= 8'd50;
      cfg_q.zero_high_width <= 8'd25;
      cfg_q.one_high_width  <= 8'd70;
    end else if (wr_en) begin
      case (idx)
        REG_TOLERANCE: cfg_q.tolerance       <= pwdata[CfgW-1:0];
        REG_PREAMBLE:  cfg_q.preamble_width  <= pwdata[CfgW-1:0];
        REG_BIT_LOW:   cfg_q.bit_low_width   <= pwdata[CfgW-1:0];
        REG_ZERO_HIGH: cfg_q.zero_high_width <= pwdata[CfgW-1:0];
        REG_ONE_HIGH:  cfg_q.one_high_width  <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TOLERANCE: prdata = 32'(cfg_q.tolerance);
      REG_PREAMBLE:  prdata = 32'(cfg_q.preamble_width);
      REG_BIT_LOW:   prdata = 32'(cfg_q.bit_low_width);
      REG_ZERO_HIGH: prdata = 32'(cfg_q.zero_high_width);
      REG_ONE_HIGH:  prdata = 32'(cfg_q.one_high_width);
      default:       prdata = 32'd0;
    endcase
  end

endmodule

[rtl/spfd_in_stage.sv]
// Input register stage of the sensor pulse frame decoder.
// Depends on spfd_pkg for the pulse_t type.
module spfd_in_stage
  import spfd_pkg::*;
#(
  parameter int unsigned WIDTH_BITS = 15
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pulse_t in_item_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pulse_t out_item_o
);

  localparam longint unsigned MaskInt = (64'd1 << WIDTH_BITS) - 64'd1;
  localparam logic [PulseW-1:0] WidthMask = MaskInt[PulseW-1:0];

  logic   valid_q;
  pulse_t item_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.frame_start <= in_item_i.frame_start;
      item_q.low_width   <= in_item_i.low_width & WidthMask;
      item_q.high_width  <= in_item_i.high_width & WidthMask;
    end
  end

endmodule

[rtl/spfd_core.sv]
// Decode stage: frame state, pulse checks, checksum and the result register.
// Depends on spfd_pkg for types, status codes and the window compare.
module spfd_core
  import spfd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pulse_t                 in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output status_e                out_status_o,
  output logic [ResW-1:0]        out_hum_o,
  output logic [ResW-1:0]        out_temp_o
);

  logic              active_q, active_d;
  logic [FrameW-1:0] bits_q, bits_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q;
  status_e           status_q;
  logic [ResW-1:0]   hum_q, temp_q;

  logic              take;
  logic              res_valid;
  status_e           res_status;
  logic [ResW-1:0]   res_hum, res_temp;
  logic              pre_ok, low_ok, zero_ok, one_ok;
  logic [FrameW-1:0] shifted;
  logic [7:0]        sum;
  logic [ResW-1:0]   raw;

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_hum_o    = hum_q;
  assign out_temp_o   = temp_q;

  assign pre_ok  = in_window(in_item_i.low_width, cfg_i.preamble_width, cfg_i.tolerance) &&
                   in_window(in_item_i.high_width, cfg_i.preamble_width, cfg_i.tolerance);
  assign low_ok  = in_window(in_item_i.low_width, cfg_i.bit_low_width, cfg_i.tolerance);
  assign zero_ok = in_window(in_item_i.high_width, cfg_i.zero_high_width, cfg_i.tolerance);
  assign one_ok  = in_window(in_item_i.high_width, cfg_i.one_high_width, cfg_i.tolerance);
  assign shifted = {bits_q[FrameW-2:0], !zero_ok};
  assign sum     = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];
  assign raw     = shifted[23:8];

  always_comb begin
    active_d   = active_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_hum    = '0;
    res_temp   = '0;
    if (in_item_i.frame_start) begin
      bits_d   = '0;
      cnt_d    = '0;
      active_d = pre_ok;
      if (!pre_ok) begin
        res_valid  = 1'b1;
        res_status = ST_BAD_PREAMBLE;
      end
    end else if (active_q) begin
      if (!low_ok) begin
        active_d   = 1'b0;
        res_valid  = 1'b1;
        res_status = ST_BAD_LOW;
      end else if (!zero_ok && !one_ok) begin
        active_d   = 1'b0;
        res_valid  = 1'b1;
        res_status = ST_BAD_HIGH;
      end else begin
        bits_d = shifted;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_d == FrameLen) begin
          active_d  = 1'b0;
          res_valid = 1'b1;
          if (sum != shifted[7:0]) begin
            res_status = ST_BAD_CHECKSUM;
          end else begin
            res_hum  = shifted[39:24];
            res_temp = raw[15] ? (16'd0 - {1'b0, raw[14:0]}) : raw;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      bits_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        active_q    <= active_d;
        bits_q      <= bits_d;
        cnt_q       <= cnt_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      status_q <= res_status;
      hum_q    <= res_hum;
      temp_q   <= res_temp;
    end
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> hum_q == '0 && temp_q == '0)
    else $error("error result carries non-zero values");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FrameLen)
    else $error("bit count beyond frame length");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !in_item_i.frame_start && !active_q |=> !out_valid_q)
    else $error("result produced for a data pair while idle");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_item_i.frame_start |=> cnt_q == '0 && bits_q == '0)
    else $error("preamble did not clear the frame");
`endif

endmodule
